### design/swcm_pkg.sv
// ----------------------------------------------------------------------------
// swcm_pkg: shared types and constants for the stereo width / correlation meter
// Command and status words between controller and datapaths, register indexes,
// accumulator limits.
// ----------------------------------------------------------------------------
package swcm_pkg;

  localparam int XW     = 45;  // cross sum, signed
  localparam int EW     = 44;  // energy sums, unsigned
  localparam int RD_W   = 16;  // correlation reading
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 8;

  localparam longint X_MAX = 64'sd17592186044415;
  localparam longint X_MIN = -X_MAX - 64'sd1;
  localparam longint E_MAX = 64'sd17592186044415;

  localparam logic [CFG_AW-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_ENABLE = 1'b1;

  localparam logic [7:0]      WIDTH_RESET = 8'd100;
  localparam logic [7:0]      WIDTH_MAX   = 8'd200;
  localparam logic [RD_W-1:0] RD_FULL     = 16'hFFFF;
  localparam logic [RD_W-1:0] RD_NONE     = 16'h0000;
  localparam logic [RD_W:0]   RD_MID      = 17'd32768;

  typedef struct packed {
    logic       capture;
    logic       mix;
    logic       div;
    logic       fix;
    logic       prod;
    logic       acc;
    logic       blk_load;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       root_init;
    logic       root_step;
    logic       root_phase;
    logic       out_load;
  } swcm_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } swcm_sts_t;

endpackage

### design/swcm_ctrl.sv
// ----------------------------------------------------------------------------
// swcm_ctrl: sequencing controller
// Walks one word through mix, divide, fix, product and accumulate steps, then
// the block-end multiply and root passes, then the output load.
// ----------------------------------------------------------------------------
module swcm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  module_enable,
  input  swcm_pkg::swcm_sts_t   sts,
  output swcm_pkg::swcm_cmd_t   cmd
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_MIX   = 11'b000_0000_0010,
    ST_DIV   = 11'b000_0000_0100,
    ST_FIX   = 11'b000_0000_1000,
    ST_PROD  = 11'b000_0001_0000,
    ST_ACC   = 11'b000_0010_0000,
    ST_LOAD  = 11'b000_0100_0000,
    ST_MUL   = 11'b000_1000_0000,
    ST_RINIT = 11'b001_0000_0000,
    ST_ROOT  = 11'b010_0000_0000,
    ST_OUT   = 11'b100_0000_0000
  } state_t;

  localparam logic [4:0] MUL_LAST  = 5'd8;
  localparam logic [4:0] ROOT_LAST = 5'd31;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_FIX;
      ST_FIX:   state_nxt = ST_PROD;
      ST_PROD:  state_nxt = ST_ACC;
      ST_ACC:   state_nxt = sts.last ? ST_LOAD : ST_OUT;
      ST_LOAD: begin
        cnt_nxt   = '0;
        state_nxt = module_enable ? ST_MUL : ST_OUT;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == MUL_LAST) state_nxt = ST_RINIT;
      end
      ST_RINIT: begin
        cnt_nxt   = '0;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == ROOT_LAST) state_nxt = ST_OUT;
      end
      ST_OUT:   if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.capture    = in_tready && in_tvalid;
    cmd.mix        = (state_r == ST_MIX);
    cmd.div        = (state_r == ST_DIV);
    cmd.fix        = (state_r == ST_FIX);
    cmd.prod       = (state_r == ST_PROD);
    cmd.acc        = (state_r == ST_ACC);
    cmd.blk_load   = (state_r == ST_LOAD);
    cmd.mul_en     = (state_r == ST_MUL) && !cnt_r[3];
    cmd.mul_idx    = cnt_r[2:0];
    cmd.root_init  = (state_r == ST_RINIT);
    cmd.root_step  = (state_r == ST_ROOT);
    cmd.root_phase = cnt_r[0];
    cmd.out_load   = (state_r == ST_OUT) && sts.out_free;
  end

endmodule

### design/swcm_mix.sv
// ----------------------------------------------------------------------------
// swcm_mix: sample datapath
// Mid/side rebuild with rounding and saturation, then the product sums.
// ----------------------------------------------------------------------------
module swcm_mix #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swcm_pkg::swcm_cmd_t                cmd,
  input  logic signed [SAMPLE_BITS-1:0]      left_in,
  input  logic signed [SAMPLE_BITS-1:0]      right_in,
  input  logic                               block_end,
  input  logic [7:0]                         width_percent,
  input  logic                               module_enable,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic                               last,
  output logic signed [swcm_pkg::XW-1:0]     cross_sum,
  output logic [swcm_pkg::EW-1:0]            left_energy,
  output logic [swcm_pkg::EW-1:0]            right_energy
);

  localparam int SB = SAMPLE_BITS;
  localparam int NW = SB + 11;          // 100*(L+R) +/- w*(L-R) + 100
  localparam int UW = SB + 5;           // offset value before /25
  localparam int SH = SB + 10;          // reciprocal shift
  localparam int MW = SB + 6;           // reciprocal width
  localparam int PW = 2 * SB;
  localparam int AW = ((PW > swcm_pkg::XW) ? PW : swcm_pkg::XW) + 1;

  localparam logic signed [NW-1:0] RND = NW'(100);
  localparam logic signed [NW-1:0] CLO = -(NW'(25) <<< (SB - 1));
  localparam logic signed [NW-1:0] CHI = -CLO - NW'(1);
  localparam longint unsigned      RECIP_L = (64'd1 << SH) / 64'd25;
  localparam logic [MW-1:0]        RECIP = MW'(RECIP_L);
  localparam logic [UW-1:0]        DIV_C = UW'(25);

  localparam logic signed [AW-1:0] XHI = AW'(swcm_pkg::X_MAX);
  localparam logic signed [AW-1:0] XLO = AW'(swcm_pkg::X_MIN);
  localparam logic [AW-1:0]        EHI = AW'(swcm_pkg::E_MAX);

  // floor((n+100)/8), clamped to the saturating range, offset to be >= 0
  function automatic logic [UW-1:0] to_offset(input logic signed [NW-1:0] n);
    logic signed [NW-1:0] t8;
    logic signed [NW-1:0] tc;
    t8 = (n + RND) >>> 3;
    if (t8 < CLO) tc = CLO;
    else if (t8 > CHI) tc = CHI;
    else tc = t8;
    return UW'(tc - CLO);
  endfunction

  // quotient correction, then shift back to a signed sample
  function automatic logic [SB-1:0] fix_q(input logic [UW-1:0] u,
                                          input logic [SB-1:0] q0);
    logic [UW-1:0] q25;
    logic [UW-1:0] rem;
    logic [SB-1:0] q;
    q25 = (UW'(q0) << 4) + (UW'(q0) << 3) + UW'(q0);
    rem = u - q25;
    q   = (rem >= DIV_C) ? q0 + SB'(1) : q0;
    return {~q[SB-1], q[SB-2:0]};
  endfunction

  logic signed [SB-1:0]          l_r, r_r;
  logic                          last_r;
  logic [UW-1:0]                 ul_r, ur_r;
  logic [SB-1:0]                 ql_r, qr_r;
  logic signed [SB-1:0]          lo_r, ro_r;
  logic signed [PW-1:0]          pxy_r, pxx_r, pyy_r;
  logic signed [swcm_pkg::XW-1:0] cross_r;
  logic [swcm_pkg::EW-1:0]       le_r, re_r;

  logic signed [SB:0]            sum_w, dif_w;
  logic signed [NW-1:0]          sx_w, dx_w, s100_w, dw_w, nl_w, nr_w;
  logic [7:0]                    wsat_w;
  logic [UW+MW-1:0]              pl_w, pr_w;
  logic signed [AW-1:0]          csum_w;
  logic [AW-1:0]                 lsum_w, rsum_w;

  assign sum_w  = (SB+1)'(l_r) + (SB+1)'(r_r);
  assign dif_w  = (SB+1)'(l_r) - (SB+1)'(r_r);
  assign sx_w   = NW'(sum_w);
  assign dx_w   = NW'(dif_w);
  assign s100_w = (sx_w <<< 6) + (sx_w <<< 5) + (sx_w <<< 2);
  assign wsat_w = (width_percent > swcm_pkg::WIDTH_MAX) ? swcm_pkg::WIDTH_MAX : width_percent;
  assign dw_w   = NW'($signed({1'b0, wsat_w})) * dx_w;
  assign nl_w   = s100_w + dw_w;
  assign nr_w   = s100_w - dw_w;

  assign pl_w = (UW+MW)'(ul_r) * (UW+MW)'(RECIP);
  assign pr_w = (UW+MW)'(ur_r) * (UW+MW)'(RECIP);

  assign csum_w = AW'(cross_r) + AW'(pxy_r);
  assign lsum_w = AW'(le_r) + AW'(pxx_r);
  assign rsum_w = AW'(re_r) + AW'(pyy_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      l_r    <= left_in;
      r_r    <= right_in;
      last_r <= block_end;
    end
    if (cmd.mix) begin
      ul_r <= to_offset(nl_w);
      ur_r <= to_offset(nr_w);
    end
    if (cmd.div) begin
      ql_r <= pl_w[SH +: SB];
      qr_r <= pr_w[SH +: SB];
    end
    if (cmd.fix) begin
      lo_r <= module_enable ? $signed(fix_q(ul_r, ql_r)) : l_r;
      ro_r <= module_enable ? $signed(fix_q(ur_r, qr_r)) : r_r;
    end
    if (cmd.prod) begin
      pxy_r <= lo_r * ro_r;
      pxx_r <= lo_r * lo_r;
      pyy_r <= ro_r * ro_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_r <= '0;
      le_r    <= '0;
      re_r    <= '0;
    end else if (cmd.blk_load) begin
      cross_r <= '0;
      le_r    <= '0;
      re_r    <= '0;
    end else if (cmd.acc && module_enable) begin
      priority if (csum_w > XHI) cross_r <= swcm_pkg::XW'(swcm_pkg::X_MAX);
      else if (csum_w < XLO)     cross_r <= swcm_pkg::XW'(swcm_pkg::X_MIN);
      else                       cross_r <= csum_w[swcm_pkg::XW-1:0];
      le_r <= (lsum_w > EHI) ? swcm_pkg::EW'(swcm_pkg::E_MAX) : lsum_w[swcm_pkg::EW-1:0];
      re_r <= (rsum_w > EHI) ? swcm_pkg::EW'(swcm_pkg::E_MAX) : rsum_w[swcm_pkg::EW-1:0];
    end
  end

  assign left_out     = lo_r;
  assign right_out    = ro_r;
  assign last         = last_r;
  assign cross_sum    = cross_r;
  assign left_energy  = le_r;
  assign right_energy = re_r;

endmodule

### design/swcm_corr.sv
// ----------------------------------------------------------------------------
// swcm_corr: block-end correlation datapath
// Forms A*B and C*C from 23x23 partial products, then finds the largest k
// with A*B*k^2 <= C^2*2^30, one bit at a time, by shift and add only.
// ----------------------------------------------------------------------------
module swcm_corr (
  input  logic                            clk,
  input  logic                            rst_n,
  input  swcm_pkg::swcm_cmd_t             cmd,
  input  logic signed [swcm_pkg::XW-1:0]  cross_sum,
  input  logic [swcm_pkg::EW-1:0]         left_energy,
  input  logic [swcm_pkg::EW-1:0]         right_energy,
  output logic [swcm_pkg::RD_W-1:0]       reading
);

  localparam int HW   = 23;
  localparam int OW   = 2 * HW;
  localparam int PRW  = 2 * OW;
  localparam int RW   = 123;
  localparam int RSH  = 30;
  localparam int KW   = 16;
  localparam logic [KW-1:0] KTOP = KW'(1) << (KW - 1);

  logic [swcm_pkg::EW-1:0] a_r, b_r;
  logic [swcm_pkg::XW-1:0] cmag_r;
  logic                    csign_r;
  logic [OW-1:0]           pp_r;
  logic [1:0]              pp_sh_r;
  logic                    pp_dst_r;
  logic                    pp_vld_r;
  logic [PRW-1:0]          p_r, c2_r;
  logic                    zero_r;
  logic [RW-1:0]           s_r, v_r, q_r, x_r, y_r;
  logic [KW-1:0]           m_r, bit_r;

  logic [OW-1:0]  opx_w, opy_w, pp_w;
  logic [HW-1:0]  xa_w, yb_w;
  logic [PRW-1:0] ppsh_w;
  logic [RW-1:0]  t_w, lim_w;
  logic           ok_w;
  logic [KW:0]    v17_w;

  assign opx_w = cmd.mul_idx[2] ? OW'(cmag_r) : OW'(a_r);
  assign opy_w = cmd.mul_idx[2] ? OW'(cmag_r) : OW'(b_r);
  assign xa_w  = cmd.mul_idx[0] ? opx_w[OW-1:HW] : opx_w[HW-1:0];
  assign yb_w  = cmd.mul_idx[1] ? opy_w[OW-1:HW] : opy_w[HW-1:0];
  assign pp_w  = OW'(xa_w) * OW'(yb_w);

  always_comb begin
    unique case (pp_sh_r)
      2'd0:    ppsh_w = PRW'(pp_r);
      2'd1:    ppsh_w = PRW'(pp_r) << HW;
      2'd2:    ppsh_w = PRW'(pp_r) << (2 * HW);
      default: ppsh_w = '0;
    endcase
  end

  assign t_w   = x_r + q_r;
  assign lim_w = RW'(c2_r) << RSH;
  assign ok_w  = (t_w <= lim_w) && !m_r[KW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) pp_vld_r <= 1'b0;
    else        pp_vld_r <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      pp_r     <= pp_w;
      pp_sh_r  <= 2'(cmd.mul_idx[0]) + 2'(cmd.mul_idx[1]);
      pp_dst_r <= cmd.mul_idx[2];
    end
    priority if (cmd.blk_load) begin
      a_r     <= left_energy;
      b_r     <= right_energy;
      csign_r <= cross_sum[swcm_pkg::XW-1];
      cmag_r  <= cross_sum[swcm_pkg::XW-1] ? swcm_pkg::XW'(-cross_sum)
                                           : swcm_pkg::XW'(cross_sum);
      p_r     <= '0;
      c2_r    <= '0;
    end else if (pp_vld_r) begin
      if (pp_dst_r) c2_r <= c2_r + ppsh_w;
      else          p_r  <= p_r + ppsh_w;
    end
    if (cmd.root_init) begin
      zero_r <= (p_r <= PRW'(1));
      s_r    <= '0;
      v_r    <= '0;
      q_r    <= RW'(p_r) << RSH;
      m_r    <= '0;
      bit_r  <= KTOP;
    end else if (cmd.root_step) begin
      if (!cmd.root_phase) begin
        x_r <= s_r + v_r;
        y_r <= v_r + (q_r << 1);
      end else begin
        if (ok_w) begin
          s_r <= t_w;
          v_r <= y_r >> 1;
          m_r <= m_r | bit_r;
        end else begin
          v_r <= v_r >> 1;
        end
        q_r   <= q_r >> 2;
        bit_r <= bit_r >> 1;
      end
    end
  end

  assign v17_w = csign_r ? swcm_pkg::RD_MID - (KW+1)'(m_r)
                         : swcm_pkg::RD_MID + (KW+1)'(m_r);

  always_comb begin
    priority if (zero_r)  reading = swcm_pkg::RD_FULL;
    else if (v17_w[KW])   reading = swcm_pkg::RD_FULL;
    else                  reading = v17_w[KW-1:0];
  end

endmodule

### design/swcm_out.sv
// ----------------------------------------------------------------------------
// swcm_out: output register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module swcm_out #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  swcm_pkg::swcm_cmd_t               cmd,
  input  logic signed [SAMPLE_BITS-1:0]     left_out,
  input  logic signed [SAMPLE_BITS-1:0]     right_out,
  input  logic                              last,
  input  logic                              module_enable,
  input  logic [swcm_pkg::RD_W-1:0]         reading,
  output logic                              out_free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [((2*SAMPLE_BITS+swcm_pkg::RD_W+7)/8)*8-1:0] out_tdata,
  output logic [0:0]                        out_tuser
);

  localparam int ODW = ((2 * SAMPLE_BITS + swcm_pkg::RD_W + 7) / 8) * 8;

  logic                       vld_r;
  logic [SAMPLE_BITS-1:0]     lo_r, ro_r;
  logic                       rv_r;
  logic [swcm_pkg::RD_W-1:0]  rd_r, rd_nxt;

  always_comb begin
    priority if (!last)        rd_nxt = swcm_pkg::RD_NONE;
    else if (!module_enable)   rd_nxt = swcm_pkg::RD_FULL;
    else                       rd_nxt = reading;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          vld_r <= 1'b0;
    else if (cmd.out_load) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      lo_r <= left_out;
      ro_r <= right_out;
      rv_r <= last;
      rd_r <= rd_nxt;
    end
  end

  assign out_free   = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = ODW'({rd_r, ro_r, lo_r});
  assign out_tuser  = rv_r;

endmodule

### design/stereo_width_correlation_meter_core.sv
// ----------------------------------------------------------------------------
// stereo_width_correlation_meter_core: stereo width with block correlation
// Mid/side width control on Q1.15 pairs and a per-block correlation reading.
// ----------------------------------------------------------------------------
// One sample word at a time: a word is accepted, then takes five datapath
// steps (mix, reciprocal divide, rounding fix, products, accumulate) and an
// output-load step that waits for a free output register; the next word is
// taken only after that load. A word with in_tlast set adds a snapshot
// that clears the sums, then while the block is enabled the 23x23
// partial-product passes that form the L*L*R*R energy product and the
// squared cross sum, a setup step and the shift-and-add root loop, which
// settles one bit of the reading at a time. A finished word waits in the
// output register while the next word is accepted. Write configuration
// only while no word is in flight.
// ----------------------------------------------------------------------------
module stereo_width_correlation_meter_core #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: left_in, right_in
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tlast,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // out_tdata: left_out, right_out, correlation_reading
  output logic [((2*SAMPLE_BITS+swcm_pkg::RD_W+7)/8)*8-1:0] out_tdata,
  // out_tuser: reading_valid
  output logic [0:0]                             out_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_wr_en,
  input  logic [swcm_pkg::CFG_AW-1:0]            cfg_addr,
  input  logic [swcm_pkg::CFG_DW-1:0]            cfg_wdata
);

  localparam int SB = SAMPLE_BITS;

  logic [7:0]                      width_r;
  logic                            enable_r;
  swcm_pkg::swcm_cmd_t             cmd;
  swcm_pkg::swcm_sts_t             sts;
  logic signed [SB-1:0]            lo_w, ro_w;
  logic                            last_w;
  logic signed [swcm_pkg::XW-1:0]  cross_w;
  logic [swcm_pkg::EW-1:0]         le_w, re_w;
  logic [swcm_pkg::RD_W-1:0]       rd_w;
  logic                            free_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= swcm_pkg::WIDTH_RESET;
      enable_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        swcm_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        swcm_pkg::REG_ENABLE: enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign sts.last     = last_w;
  assign sts.out_free = free_w;

  swcm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .module_enable (enable_r),
    .sts           (sts),
    .cmd           (cmd)
  );

  swcm_mix #(.SAMPLE_BITS(SB)) u_mix (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .left_in       ($signed(in_tdata[SB-1:0])),
    .right_in      ($signed(in_tdata[2*SB-1:SB])),
    .block_end     (in_tlast),
    .width_percent (width_r),
    .module_enable (enable_r),
    .left_out      (lo_w),
    .right_out     (ro_w),
    .last          (last_w),
    .cross_sum     (cross_w),
    .left_energy   (le_w),
    .right_energy  (re_w)
  );

  swcm_corr u_corr (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cross_sum    (cross_w),
    .left_energy  (le_w),
    .right_energy (re_w),
    .reading      (rd_w)
  );

  swcm_out #(.SAMPLE_BITS(SB)) u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .left_out      (lo_w),
    .right_out     (ro_w),
    .last          (last_w),
    .module_enable (enable_r),
    .reading       (rd_w),
    .out_free      (free_w),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser)
  );

endmodule

### design/swcm_chk.sv
// ----------------------------------------------------------------------------
// swcm_chk: port-level checks for the correlation meter
// Tracks words in flight and checks output ordering and reading rules.
// ----------------------------------------------------------------------------
module swcm_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,
  input logic                                   in_tlast,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic [((2*SAMPLE_BITS+swcm_pkg::RD_W+7)/8)*8-1:0] out_tdata,
  input logic [0:0]                             out_tuser,
  input logic                                   out_tvalid,
  input logic                                   out_tready
);

  localparam int RD_LO = 2 * SAMPLE_BITS;

  logic       in_acc, out_acc;
  logic [2:0] pend_r;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_r + 3'(in_acc) - 3'(out_acc);
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("new word taken while one is in work");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pend_r != 3'd0)
    else $error("output word without an accepted input");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd2)
    else $error("more than two words in flight");

  a_reading_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[RD_LO +: swcm_pkg::RD_W] == '0)
    else $error("reading nonzero on a word that is not a block end");

endmodule

bind stereo_width_correlation_meter_core swcm_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_swcm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
